>>> rtl/pcsc_pkg.sv
// Package for the packet class statistics counter.
// Holds item and record types, header offsets, class codes and default sizes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pcsc_pkg;

    localparam int DEF_COUNT_WIDTH = 32;
    localparam int DEF_QUEUE_DEPTH = 4;

    localparam int POS_W  = 7;
    localparam int LEN_W  = 16;
    localparam int SUM_W  = 48;
    localparam int OUT_CW = 32;

    // Header layout, as byte positions within the frame.
    localparam logic [POS_W-1:0] TYPE_OFFSET  = 7'd12;
    localparam logic [POS_W-1:0] NET_HDR_POS  = 7'd14;
    localparam logic [POS_W-1:0] PROTO_OFFSET = 7'd23;
    // TCP flags sit at NET_HDR_POS + 13 + 4 * IHL.
    localparam logic [POS_W-1:0] FLAG_BASE    = 7'd27;
    localparam logic [POS_W-1:0] POS_MAX      = 7'd127;

    localparam logic [15:0] ETH_IPV4    = 16'h0800;
    localparam logic [15:0] ETH_ARP     = 16'h0806;
    localparam logic [7:0]  PROTO_TCP   = 8'd6;
    localparam logic [7:0]  PROTO_UDP   = 8'd17;
    localparam logic [7:0]  SYN_PATTERN = 8'h02;

    localparam logic [1:0] FC_IPV4  = 2'd0;
    localparam logic [1:0] FC_ARP   = 2'd1;
    localparam logic [1:0] FC_OTHER = 2'd2;

    localparam logic [1:0] TC_UDP   = 2'd0;
    localparam logic [1:0] TC_TCP   = 2'd1;
    localparam logic [1:0] TC_OTHER = 2'd2;

    // Indexes into the class counter bank.
    localparam int CNT_IPV4 = 0;
    localparam int CNT_ARP  = 1;
    localparam int CNT_TCP  = 2;
    localparam int CNT_SYN  = 3;
    localparam int CNT_UDP  = 4;
    localparam int CNT_NUM  = 5;

    typedef struct packed {
        logic [7:0]       data_byte;
        logic             packet_start;
        logic             packet_end;
        logic [LEN_W-1:0] wire_length;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        frame_class;
        logic [1:0]        transport_class;
        logic              syn_only;
        logic [OUT_CW-1:0] packet_total;
        logic [SUM_W-1:0]  byte_total;
        logic [OUT_CW-1:0] ipv4_total;
        logic [OUT_CW-1:0] arp_total;
        logic [OUT_CW-1:0] tcp_total;
        logic [OUT_CW-1:0] tcp_syn_total;
        logic [OUT_CW-1:0] udp_total;
    } t_out_item;

    // One classified frame, handed from the parser to the counter stage.
    typedef struct packed {
        logic [1:0]       frame_class;
        logic [1:0]       transport_class;
        logic             syn_only;
        logic [LEN_W-1:0] wire_length;
    } t_cls_rec;

endpackage

`default_nettype wire

>>> rtl/pcsc_front.sv
// Frame parser: captures header fields byte by byte and classifies the frame.
// Depends on pcsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pcsc_front
    import pcsc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_accept,
    input  wire t_in_item i_item,
    output logic          o_rec_push,
    output t_cls_rec      o_rec
);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [15:0]      r_etype, n_etype;
    logic [7:0]       r_proto, n_proto;
    logic [3:0]       r_ihl, n_ihl;
    logic [7:0]       r_flags, n_flags;

    logic [POS_W-1:0] pos_b;
    logic [POS_W-1:0] flag_pos;
    logic [15:0]      etype_b;
    logic [7:0]       proto_b;
    logic [3:0]       ihl_b;
    logic [7:0]       flags_b;

    always_comb begin
        // A start mark clears the frame before this byte is taken in.
        pos_b   = i_item.packet_start ? '0 : r_pos;
        etype_b = i_item.packet_start ? '0 : r_etype;
        proto_b = i_item.packet_start ? '0 : r_proto;
        ihl_b   = i_item.packet_start ? '0 : r_ihl;
        flags_b = i_item.packet_start ? '0 : r_flags;

        flag_pos = FLAG_BASE + {1'b0, ihl_b, 2'b00};

        n_etype = etype_b;
        n_proto = proto_b;
        n_ihl   = ihl_b;
        n_flags = flags_b;
        if (pos_b == TYPE_OFFSET) begin
            n_etype = {i_item.data_byte, etype_b[7:0]};
        end else if (pos_b == TYPE_OFFSET + 7'd1) begin
            n_etype = {etype_b[15:8], i_item.data_byte};
        end else if (pos_b == NET_HDR_POS) begin
            n_ihl = i_item.data_byte[3:0];
        end else if (pos_b == PROTO_OFFSET) begin
            n_proto = i_item.data_byte;
        end else if (pos_b == flag_pos) begin
            n_flags = i_item.data_byte;
        end

        n_pos = (pos_b < POS_MAX) ? pos_b + 7'd1 : pos_b;

        if (n_etype == ETH_IPV4) begin
            o_rec.frame_class = FC_IPV4;
        end else if (n_etype == ETH_ARP) begin
            o_rec.frame_class = FC_ARP;
        end else begin
            o_rec.frame_class = FC_OTHER;
        end

        o_rec.syn_only = 1'b0;
        if (n_proto == PROTO_TCP) begin
            o_rec.transport_class = TC_TCP;
            o_rec.syn_only        = (n_flags == SYN_PATTERN);
        end else if (n_proto == PROTO_UDP) begin
            o_rec.transport_class = TC_UDP;
        end else begin
            o_rec.transport_class = TC_OTHER;
        end

        o_rec.wire_length = i_item.wire_length;
    end

    assign o_rec_push = i_accept && i_item.packet_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_etype <= '0;
            r_proto <= '0;
            r_ihl   <= '0;
            r_flags <= '0;
        end else if (i_accept) begin
            if (i_item.packet_end) begin
                // The next byte opens a new frame even without a start mark.
                r_pos   <= '0;
                r_etype <= '0;
                r_proto <= '0;
                r_ihl   <= '0;
                r_flags <= '0;
            end else begin
                r_pos   <= n_pos;
                r_etype <= n_etype;
                r_proto <= n_proto;
                r_ihl   <= n_ihl;
                r_flags <= n_flags;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/pcsc_queue.sv
// Short register queue that decouples the parser from the counter stage.
// Depends on pcsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pcsc_queue
    import pcsc_pkg::*;
#(
    parameter int DEPTH = DEF_QUEUE_DEPTH
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  wire t_cls_rec i_rec,
    output logic          o_full,
    input  wire logic     i_pop,
    output t_cls_rec      o_rec,
    output logic          o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_cls_rec         r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_rec   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/pcsc_back.sv
// Counter stage: updates the statistics counters and holds the output item.
// Depends on pcsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pcsc_back
    import pcsc_pkg::*;
#(
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_cls_rec i_rec,
    input  wire logic     i_rec_empty,
    output logic          o_rec_pop,
    input  wire logic     i_pop,
    output logic          o_empty,
    output t_out_item     o_item
);

    logic [COUNT_WIDTH-1:0] r_frames;
    logic [COUNT_WIDTH-1:0] r_cls_cnt [CNT_NUM];
    logic [SUM_W-1:0]       r_bytes;
    logic                   r_valid;
    logic [1:0]             r_fclass;
    logic [1:0]             r_tclass;
    logic                   r_syn;

    logic [63:0] frames_ext;
    logic [63:0] ipv4_ext, arp_ext, tcp_ext, syn_ext, udp_ext;

    // Counters only move when a new item lands in the output register, so
    // the output item can be read straight from them.
    assign o_rec_pop = !i_rec_empty && (!r_valid || i_pop);
    assign o_empty   = !r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_frames <= '0;
            r_bytes  <= '0;
            for (int k = 0; k < CNT_NUM; k++) begin
                r_cls_cnt[k] <= '0;
            end
        end else if (o_rec_pop) begin
            r_valid  <= 1'b1;
            r_frames <= r_frames + COUNT_WIDTH'(1);
            r_bytes  <= r_bytes + SUM_W'(i_rec.wire_length);
            if (i_rec.frame_class == FC_IPV4) begin
                r_cls_cnt[CNT_IPV4] <= r_cls_cnt[CNT_IPV4] + COUNT_WIDTH'(1);
            end else if (i_rec.frame_class == FC_ARP) begin
                r_cls_cnt[CNT_ARP] <= r_cls_cnt[CNT_ARP] + COUNT_WIDTH'(1);
            end
            if (i_rec.transport_class == TC_TCP) begin
                r_cls_cnt[CNT_TCP] <= r_cls_cnt[CNT_TCP] + COUNT_WIDTH'(1);
                if (i_rec.syn_only) begin
                    r_cls_cnt[CNT_SYN] <= r_cls_cnt[CNT_SYN] + COUNT_WIDTH'(1);
                end
            end else if (i_rec.transport_class == TC_UDP) begin
                r_cls_cnt[CNT_UDP] <= r_cls_cnt[CNT_UDP] + COUNT_WIDTH'(1);
            end
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rec_pop) begin
            r_fclass <= i_rec.frame_class;
            r_tclass <= i_rec.transport_class;
            r_syn    <= i_rec.syn_only;
        end
    end

    assign frames_ext = 64'(r_frames);
    assign ipv4_ext   = 64'(r_cls_cnt[CNT_IPV4]);
    assign arp_ext    = 64'(r_cls_cnt[CNT_ARP]);
    assign tcp_ext    = 64'(r_cls_cnt[CNT_TCP]);
    assign syn_ext    = 64'(r_cls_cnt[CNT_SYN]);
    assign udp_ext    = 64'(r_cls_cnt[CNT_UDP]);

    always_comb begin
        o_item.frame_class     = r_fclass;
        o_item.transport_class = r_tclass;
        o_item.syn_only        = r_syn;
        o_item.packet_total    = frames_ext[OUT_CW-1:0];
        o_item.byte_total      = r_bytes;
        o_item.ipv4_total      = ipv4_ext[OUT_CW-1:0];
        o_item.arp_total       = arp_ext[OUT_CW-1:0];
        o_item.tcp_total       = tcp_ext[OUT_CW-1:0];
        o_item.tcp_syn_total   = syn_ext[OUT_CW-1:0];
        o_item.udp_total       = udp_ext[OUT_CW-1:0];
    end

endmodule

`default_nettype wire

>>> rtl/packet_class_stats_counter_top.sv
// A frame's result passes the queue entry, then the counter register, on its way
// to the output, which it reaches once the output side is free. Throughput: one
// byte per cycle; the parser takes a byte every cycle unless the record queue is
// full; the counter stage retires one record a cycle while the output side is free.
// Reset (synchronous, active low) clears the captures, the queue and all counters.
`timescale 1ns / 1ps
`default_nettype none

module packet_class_stats_counter_top
    import pcsc_pkg::*;
#(
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire t_in_item i_item,
    output t_out_item     o_item,
    output logic          empty,
    input  wire logic     pop
);

    logic     accept;
    logic     q_push, q_full, q_pop, q_empty;
    t_cls_rec rec_in, rec_out;

    assign full   = q_full;
    assign accept = push && !q_full;

    pcsc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_item     (i_item),
        .o_rec_push (q_push),
        .o_rec      (rec_in)
    );

    pcsc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_rec   (rec_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_rec   (rec_out),
        .o_empty (q_empty)
    );

    pcsc_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec       (rec_out),
        .i_rec_empty (q_empty),
        .o_rec_pop   (q_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_item      (o_item)
    );

    // A frame end is never pushed into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("record pushed into full queue");

    // A record taken from the queue always shows up as the next output item.
    a_pop_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |=> !empty)
        else $error("queue record lost on its way to the output");

    // A SYN flag only ever comes with a TCP transport class.
    a_syn_tcp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_item.syn_only) |-> (o_item.transport_class == TC_TCP))
        else $error("SYN flag on a non-TCP item");

endmodule

`default_nettype wire

>>> tb/sv/pcsc_checker.sv
// Checker for the packet class statistics counter: predicts each frame's record
// from the accepted bytes and compares it with the records the block hands out.
// Depends on pcsc_pkg for the item types, header offsets and class codes.
`timescale 1ns / 1ps

module pcsc_checker
    import pcsc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  logic      i_full,
    input  t_in_item  i_in,
    input  t_out_item i_out,
    input  logic      i_empty,
    input  logic      i_pop,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_results
);

    logic [POS_W-1:0]  cur_pos;
    logic [15:0]       cap_ethertype;
    logic [7:0]        cap_proto;
    logic [3:0]        cap_ihl;
    logic [7:0]        cap_flags;
    logic [OUT_CW-1:0] frame_total;
    logic [SUM_W-1:0]  length_total;
    logic [OUT_CW-1:0] class_total [CNT_NUM];
    t_out_item         expected_records[$];
    int                fails = 0;
    int                records_checked = 0;

    assign o_fail_count = fails;
    assign o_pending    = expected_records.size();
    assign o_results    = records_checked;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
        fails++;
    endtask

    task automatic clear_capture();
        cur_pos       = '0;
        cap_ethertype = '0;
        cap_proto     = '0;
        cap_ihl       = '0;
        cap_flags     = '0;
    endtask

    // Takes one frame byte into the capture state; a frame end yields one record.
    task automatic take_byte(input t_in_item it);
        logic [POS_W-1:0] flag_at;
        t_out_item        rec;
        if (it.packet_start) begin
            clear_capture();
        end
        flag_at = FLAG_BASE + {1'b0, cap_ihl, 2'b00};
        if (cur_pos == TYPE_OFFSET) begin
            cap_ethertype[15:8] = it.data_byte;
        end else if (cur_pos == TYPE_OFFSET + 7'd1) begin
            cap_ethertype[7:0] = it.data_byte;
        end else if (cur_pos == NET_HDR_POS) begin
            cap_ihl = it.data_byte[3:0];
        end else if (cur_pos == PROTO_OFFSET) begin
            cap_proto = it.data_byte;
        end else if (cur_pos == flag_at) begin
            cap_flags = it.data_byte;
        end
        if (cur_pos != POS_MAX) begin
            cur_pos = cur_pos + 7'd1;
        end
        if (!it.packet_end) begin
            return;
        end

        rec = '0;
        if (cap_ethertype == ETH_IPV4) begin
            rec.frame_class = FC_IPV4;
        end else if (cap_ethertype == ETH_ARP) begin
            rec.frame_class = FC_ARP;
        end else begin
            rec.frame_class = FC_OTHER;
        end
        // The transport check does not look at the EtherType.
        if (cap_proto == PROTO_TCP) begin
            rec.transport_class = TC_TCP;
            rec.syn_only = (cap_flags == SYN_PATTERN);
        end else if (cap_proto == PROTO_UDP) begin
            rec.transport_class = TC_UDP;
        end else begin
            rec.transport_class = TC_OTHER;
        end

        length_total = length_total + SUM_W'(it.wire_length);
        frame_total  = frame_total + 1'b1;
        if (rec.frame_class == FC_IPV4) begin
            class_total[CNT_IPV4] = class_total[CNT_IPV4] + 1'b1;
        end else if (rec.frame_class == FC_ARP) begin
            class_total[CNT_ARP] = class_total[CNT_ARP] + 1'b1;
        end
        if (rec.transport_class == TC_TCP) begin
            class_total[CNT_TCP] = class_total[CNT_TCP] + 1'b1;
            if (rec.syn_only) begin
                class_total[CNT_SYN] = class_total[CNT_SYN] + 1'b1;
            end
        end else if (rec.transport_class == TC_UDP) begin
            class_total[CNT_UDP] = class_total[CNT_UDP] + 1'b1;
        end

        rec.packet_total  = frame_total;
        rec.byte_total    = length_total;
        rec.ipv4_total    = class_total[CNT_IPV4];
        rec.arp_total     = class_total[CNT_ARP];
        rec.tcp_total     = class_total[CNT_TCP];
        rec.tcp_syn_total = class_total[CNT_SYN];
        rec.udp_total     = class_total[CNT_UDP];
        expected_records.push_back(rec);
        clear_capture();
    endtask

    task automatic check_record(input t_out_item got);
        t_out_item want;
        if (expected_records.size() == 0) begin
            report_mismatch("record with none expected, packet_total", got.packet_total, 0);
            return;
        end
        want = expected_records.pop_front();
        records_checked++;
        if (got.frame_class !== want.frame_class)
            report_mismatch("frame_class", got.frame_class, want.frame_class);
        if (got.transport_class !== want.transport_class)
            report_mismatch("transport_class", got.transport_class, want.transport_class);
        if (got.syn_only !== want.syn_only)
            report_mismatch("syn_only", got.syn_only, want.syn_only);
        if (got.packet_total !== want.packet_total)
            report_mismatch("packet_total", got.packet_total, want.packet_total);
        if (got.byte_total !== want.byte_total)
            report_mismatch("byte_total", got.byte_total, want.byte_total);
        if (got.ipv4_total !== want.ipv4_total)
            report_mismatch("ipv4_total", got.ipv4_total, want.ipv4_total);
        if (got.arp_total !== want.arp_total)
            report_mismatch("arp_total", got.arp_total, want.arp_total);
        if (got.tcp_total !== want.tcp_total)
            report_mismatch("tcp_total", got.tcp_total, want.tcp_total);
        if (got.tcp_syn_total !== want.tcp_syn_total)
            report_mismatch("tcp_syn_total", got.tcp_syn_total, want.tcp_syn_total);
        if (got.udp_total !== want.udp_total)
            report_mismatch("udp_total", got.udp_total, want.udp_total);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_capture();
            frame_total  = '0;
            length_total = '0;
            for (int k = 0; k < CNT_NUM; k++) begin
                class_total[k] = '0;
            end
            expected_records.delete();
        end else begin
            // A record can never leave in the cycle its last byte enters.
            if (i_pop && !i_empty) begin
                check_record(i_out);
            end
            if (i_push && !i_full) begin
                take_byte(i_in);
            end
        end
    end

endmodule

>>> tb/sv/tb.sv
// Testbench top for the packet class statistics counter: drives frames byte by
// byte with random gaps and stalls, and gives the verdict from pcsc_checker.
// Depends on pcsc_pkg, packet_class_stats_counter_top and pcsc_checker.
`timescale 1ns / 1ps

module tb;
    import pcsc_pkg::*;

    localparam int ITEM_TARGET  = 1150;
    localparam int FRAME_TARGET = 60;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 16;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push    = 1'b0;
    logic      pop     = 1'b0;
    t_in_item  in_item = '0;
    logic      full;
    logic      empty;
    t_out_item out_item;

    int fail_count;
    int pending;
    int records_checked;
    int items_sent  = 0;
    int frames_sent = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_done = 1'b0;

    packet_class_stats_counter_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_item  (in_item),
        .o_item  (out_item),
        .empty   (empty),
        .pop     (pop)
    );

    pcsc_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_in         (in_item),
        .i_out        (out_item),
        .i_empty      (empty),
        .i_pop        (pop),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_results    (records_checked)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic send_byte(input logic [7:0] b, input logic s, input logic e,
                             input logic [15:0] len);
        t_in_item it;
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        it.data_byte    = b;
        it.packet_start = s;
        it.packet_end   = e;
        it.wire_length  = len;
        in_item <= it;
        push    <= 1'b1;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        items_sent++;
        if (e) frames_sent++;
    endtask

    // Header bytes go to their fixed places; every other byte is random.
    task automatic send_frame(input int nbytes, input bit with_start, input bit with_end,
                              input logic [15:0] ethertype, input logic [7:0] ip_first,
                              input logic [7:0] proto, input logic [7:0] flags,
                              input logic [15:0] end_len);
        int         flag_at;
        logic [7:0] b;
        bit         last;
        flag_at = 27 + 4 * ip_first[3:0];
        for (int i = 0; i < nbytes; i++) begin
            b = $urandom;
            if (i == 12) b = ethertype[15:8];
            else if (i == 13) b = ethertype[7:0];
            else if (i == 14) b = ip_first;
            else if (i == 23) b = proto;
            else if (i == flag_at) b = flags;
            last = with_end && (i == nbytes - 1);
            send_byte(b, with_start && (i == 0), last, last ? end_len : 16'($urandom));
        end
    endtask

    task automatic send_random_frame();
        logic [15:0] ethertype;
        logic [7:0]  ip_first;
        logic [7:0]  proto;
        logic [7:0]  flags;
        logic [15:0] end_len;
        int          flag_at;
        int          nbytes;
        int          kind;
        int          r;

        r = $urandom_range(9);
        if (r < 4) ethertype = ETH_IPV4;
        else if (r < 6) ethertype = ETH_ARP;
        else if (r == 6) ethertype = ETH_ARP ^ (16'h1 << $urandom_range(15));
        else ethertype = $urandom;

        r = $urandom_range(9);
        if (r < 5) ip_first = 8'h45;
        else if (r < 7) ip_first = {4'h4, 4'($urandom)};
        else ip_first = $urandom;

        r = $urandom_range(9);
        if (r < 4) proto = PROTO_TCP;
        else if (r < 7) proto = PROTO_UDP;
        else proto = $urandom;

        r = $urandom_range(9);
        if (r < 5) flags = SYN_PATTERN;
        else if (r < 7) flags = 8'h12;
        else flags = $urandom;

        r = $urandom_range(9);
        if (r == 0) end_len = 16'h0000;
        else if (r == 1) end_len = 16'hFFFF;
        else end_len = $urandom;

        flag_at = 27 + 4 * ip_first[3:0];
        r = $urandom_range(9);
        if (r < 6) nbytes = flag_at + 1 + $urandom_range(6);
        else if (r < 9) nbytes = $urandom_range(flag_at, 1);
        else nbytes = $urandom_range(180, 128);

        kind = $urandom_range(19);
        if (kind < 15) begin
            send_frame(nbytes, 1'b1, 1'b1, ethertype, ip_first, proto, flags, end_len);
        end else if (kind < 17) begin
            send_frame(1, 1'b1, 1'b1, ethertype, ip_first, proto, flags, end_len);
        end else if (kind == 17) begin
            // No start mark: the capture starts clear only when the previous frame had an end.
            send_frame(nbytes, 1'b0, 1'b1, ethertype, ip_first, proto, flags, end_len);
        end else if (kind == 18) begin
            // Cut off without an end; the next start mark has to discard it.
            send_frame($urandom_range(40, 1), 1'b1, 1'b0, ethertype, ip_first, proto,
                       flags, end_len);
        end else begin
            send_frame($urandom_range(30, 1), 1'b0, 1'b0, ethertype, ip_first, proto,
                       flags, end_len);
        end
    endtask

    // Receiver: random stalls, plus one long hold-off so the block fills up.
    initial begin : receiver
        forever begin
            @(posedge i_clk);
            if (!hold_done && records_checked >= 6) begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                pop <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial begin : watchdog
        int quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty)) quiet = 0;
            else quiet++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // A one-byte frame, a short ARP frame that stops before the IP header,
        // and a lone end byte with no start mark.
        send_frame(1, 1'b1, 1'b1, ETH_IPV4, 8'h45, PROTO_TCP, SYN_PATTERN, 16'hFFFF);
        send_frame(14, 1'b1, 1'b1, ETH_ARP, 8'hFF, PROTO_UDP, 8'hFF, 16'h0000);
        send_frame(1, 1'b0, 1'b1, ETH_ARP, 8'h00, 8'h00, 8'h00, 16'd60);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase
            while (items_sent < (ph + 1) * ITEM_TARGET / 4) send_random_frame();
        end
        while (frames_sent < FRAME_TARGET) send_random_frame();
        push <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/pcsc_pkg.sv
rtl/pcsc_front.sv
rtl/pcsc_queue.sv
rtl/pcsc_back.sv
rtl/packet_class_stats_counter_top.sv
tb/sv/pcsc_checker.sv
tb/sv/tb.sv
